@@ sv/bpsc_pkg.sv @@
// Shared types and constants for the BMP pixel stream converter.
// Used by bpsc_parse, bpsc_out and the top level; no dependencies.
package bpsc_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int DIM_LIMIT   = 4096;
  localparam int WIDTH_LIMIT = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int COLOR_W     = 8;
  localparam int PAL_W       = 3 * COLOR_W;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int BIR_W       = 14;
  localparam int CFG_IDX_W   = 3;

  localparam int GRAY_KR     = 218;
  localparam int GRAY_KG     = 732;
  localparam int GRAY_KB     = 74;
  localparam int GRAY_SHIFT  = 10;
  localparam int GRAY_SUM_W  = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_OUT_FORMAT    = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_TOP_DOWN      = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_PALETTE = 1'b0,
    MODE_PIXEL   = 1'b1
  } in_mode_t;

  typedef struct packed {
    logic             source_format;
    logic             out_format;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             top_down;
  } cfg_t;

  typedef struct packed {
    logic               use_pal;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic               last;
  } pix_meta_t;

endpackage

@@ sv/bpsc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bpsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bpsc_parse.sv @@
// Byte parser: row, column and pixel-byte counters, palette access issue
// and the stage register that waits on the palette read. Uses bpsc_pkg.
module bpsc_parse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpsc_pkg::cfg_t                      cfg,
  input  logic                                in_accept,
  input  logic                                in_mode,
  input  logic [bpsc_pkg::PAL_AW-1:0]         pal_index,
  input  logic [bpsc_pkg::PAL_W-1:0]          pal_entry,
  input  logic [bpsc_pkg::COLOR_W-1:0]        data_byte,
  input  logic                                advance,
  output logic                                pal_we,
  output logic [bpsc_pkg::PAL_AW-1:0]         pal_waddr,
  output logic [bpsc_pkg::PAL_W-1:0]          pal_wdata,
  output logic                                pal_re,
  output logic [bpsc_pkg::PAL_AW-1:0]         pal_raddr,
  output logic                                s1_valid,
  output bpsc_pkg::pix_meta_t                 s1_meta
);
  import bpsc_pkg::*;

  logic [1:0]         bip_r, bip_nxt;
  logic [15:0]        held_r, held_nxt;
  logic [BIR_W-1:0]   bir_r, bir_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic               s1_vld_r, s1_vld_nxt;
  pix_meta_t          s1_meta_r, s1_meta_nxt;

  logic [DIM_W-1:0]   w_clamp, h_clamp;
  logic [POS_W-1:0]   w_m1, h_m1;
  logic [BIR_W-1:0]   data_len, row_len, len_p3;
  logic [BIR_W:0]     bir_p1;
  logic               in_data, row_end, produce, pix_in;

  always_comb begin
    if (cfg.image_width == '0) begin
      w_clamp = DIM_W'(1);
    end else if (cfg.image_width > DIM_W'(WIDTH_LIMIT)) begin
      w_clamp = DIM_W'(WIDTH_LIMIT);
    end else begin
      w_clamp = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h_clamp = DIM_W'(1);
    end else if (cfg.image_height > DIM_W'(DIM_LIMIT)) begin
      h_clamp = DIM_W'(DIM_LIMIT);
    end else begin
      h_clamp = cfg.image_height;
    end
  end

  assign w_m1     = POS_W'(w_clamp - DIM_W'(1));
  assign h_m1     = POS_W'(h_clamp - DIM_W'(1));
  assign data_len = cfg.source_format ?
                    (BIR_W'(w_clamp) + BIR_W'({w_clamp, 1'b0})) : BIR_W'(w_clamp);
  assign len_p3   = data_len + BIR_W'(3);
  assign row_len  = {len_p3[BIR_W-1:2], 2'b00};
  assign bir_p1   = {1'b0, bir_r} + (BIR_W+1)'(1);
  assign in_data  = bir_r < data_len;
  assign row_end  = bir_p1 >= {1'b0, row_len};
  assign pix_in   = in_accept && (in_mode == MODE_PIXEL);

  assign pal_we    = in_accept && (in_mode == MODE_PALETTE);
  assign pal_waddr = pal_index;
  assign pal_wdata = pal_entry;
  assign pal_raddr = data_byte;
  assign pal_re    = pix_in && in_data && !cfg.source_format;

  always_comb begin
    bip_nxt     = bip_r;
    held_nxt    = held_r;
    bir_nxt     = bir_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    produce     = 1'b0;
    s1_meta_nxt.use_pal = !cfg.source_format;
    s1_meta_nxt.red     = data_byte;
    s1_meta_nxt.green   = held_r[15:8];
    s1_meta_nxt.blue    = held_r[7:0];
    s1_meta_nxt.column  = col_r;
    s1_meta_nxt.row     = cfg.top_down ? row_r : (h_m1 - row_r);
    s1_meta_nxt.last    = (col_r == w_m1) && (row_r == h_m1);
    if (pix_in) begin
      if (in_data) begin
        if (!cfg.source_format) begin
          produce = 1'b1;
          bip_nxt = 2'd0;
        end else begin
          case (bip_r)
            2'd0: begin
              held_nxt = {8'h00, data_byte};
              bip_nxt  = 2'd1;
            end
            2'd1: begin
              held_nxt = {data_byte, held_r[7:0]};
              bip_nxt  = 2'd2;
            end
            default: begin
              produce = 1'b1;
              bip_nxt = 2'd0;
            end
          endcase
        end
        if (produce) begin
          col_nxt = col_r + POS_W'(1);
        end
      end
      if (row_end) begin
        bir_nxt = '0;
        bip_nxt = 2'd0;
        col_nxt = '0;
        row_nxt = (row_r >= h_m1) ? '0 : row_r + POS_W'(1);
      end else begin
        bir_nxt = bir_p1[BIR_W-1:0];
      end
    end
    s1_vld_nxt = advance ? produce : s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bip_r    <= '0;
      held_r   <= '0;
      bir_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      bip_r    <= bip_nxt;
      held_r   <= held_nxt;
      bir_r    <= bir_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

  assign s1_valid = s1_vld_r;
  assign s1_meta  = s1_meta_r;

  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    bip_r != 2'd3) else $error("pixel byte count out of range");
  a_read_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    pal_re |-> advance) else $error("palette read while stage held");
  a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(pal_re && pal_we)) else $error("palette read and write in one cycle");

endmodule

@@ sv/bpsc_out.sv @@
// Output stage: palette data select, gray weighting and the result register.
// Uses bpsc_pkg.
module bpsc_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               gray_mode,
  input  logic                               s1_valid,
  input  bpsc_pkg::pix_meta_t                s1_meta,
  input  logic [bpsc_pkg::PAL_W-1:0]         pal_rdata,
  output logic                               advance,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [55:0]                        out_data,
  output logic                               out_last
);
  import bpsc_pkg::*;

  logic                     ovld_r, ovld_nxt;
  logic [55:0]              odata_r, odata_nxt;
  logic                     olast_r;
  logic [COLOR_W-1:0]       r_sel, g_sel, b_sel, gray;
  logic [GRAY_SUM_W-1:0]    gsum;

  always_comb begin
    if (s1_meta.use_pal) begin
      r_sel = pal_rdata[23:16];
      g_sel = pal_rdata[15:8];
      b_sel = pal_rdata[7:0];
    end else begin
      r_sel = s1_meta.red;
      g_sel = s1_meta.green;
      b_sel = s1_meta.blue;
    end
  end

  assign gsum = GRAY_SUM_W'(r_sel * GRAY_SUM_W'(GRAY_KR))
              + GRAY_SUM_W'(g_sel * GRAY_SUM_W'(GRAY_KG))
              + GRAY_SUM_W'(b_sel * GRAY_SUM_W'(GRAY_KB));
  assign gray = gsum[GRAY_SHIFT +: COLOR_W];

  assign advance  = !ovld_r || out_ready;
  assign ovld_nxt = advance ? s1_valid : ovld_r;

  always_comb begin
    if (gray_mode) begin
      odata_nxt = {s1_meta.row, s1_meta.column, gray, 24'h000000};
    end else begin
      odata_nxt = {s1_meta.row, s1_meta.column, 8'h00, b_sel, g_sel, r_sel};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      odata_r <= odata_nxt;
      olast_r <= s1_meta.last;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;
  assign out_last  = olast_r;

endmodule

@@ sv/bmp_pixel_stream_converter_top.sv @@
// Top level of the BMP pixel stream converter: configuration registers,
// palette RAM, byte parser and output stage. Uses bpsc_pkg and all bpsc_ modules.
//
// Use: in_ carries one word per cycle while in_tready is high. in_tuser = 0
// writes a palette entry (index, red, green, blue in in_tdata); in_tuser = 1
// carries one raw byte of the BMP pixel area, row padding included. Each
// completed pixel leaves on out_ as red, green, blue (or gray) with its column
// and output row; out_tlast marks the last pixel of the image. Padding bytes
// and the first two bytes of a 24-bit pixel give no word.
// The cfg_ channel writes one register per handshake and is always ready;
// write only while the block is idle.
// Throughput: one input word per cycle while in_tready is high. A pixel
// reaches out_ through the parse stage register, which waits on the
// registered palette RAM read, and then through the output register.
// Reset clears counters and pipeline valids and loads the register defaults;
// palette contents are undefined until written.
// When a word waits in the output register and out_tready is low, in_tready
// drops in the same cycle and the palette-read stage holds its word, if any.
module bmp_pixel_stream_converter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,   // palette_index, palette_red,
                                                          // palette_green, palette_blue,
                                                          // data_byte
  input  logic                                in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata,  // red, green, blue, gray,
                                                          // column, row
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpsc_pkg::DIM_W-1:0]          cfg_data
);
  import bpsc_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  pix_meta_t            s1_meta;
  logic                 s1_valid, advance, in_accept;
  logic                 pal_we, pal_re;
  logic [PAL_AW-1:0]    pal_waddr, pal_raddr;
  logic [PAL_W-1:0]     pal_wdata, pal_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_FORMAT: cfg_nxt.source_format = cfg_data[0];
        REG_OUT_FORMAT:    cfg_nxt.out_format    = cfg_data[0];
        REG_IMAGE_WIDTH:   cfg_nxt.image_width   = cfg_data;
        REG_IMAGE_HEIGHT:  cfg_nxt.image_height  = cfg_data;
        REG_TOP_DOWN:      cfg_nxt.top_down      = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_format <= 1'b0;
      cfg_r.out_format    <= 1'b0;
      cfg_r.image_width   <= DIM_W'(1);
      cfg_r.image_height  <= DIM_W'(1);
      cfg_r.top_down      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = advance;
  assign in_accept = in_tvalid && in_tready;

  bpsc_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  bpsc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_mode   (in_tuser),
    .pal_index (in_tdata[7:0]),
    .pal_entry ({in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]}),
    .data_byte (in_tdata[39:32]),
    .advance   (advance),
    .pal_we    (pal_we),
    .pal_waddr (pal_waddr),
    .pal_wdata (pal_wdata),
    .pal_re    (pal_re),
    .pal_raddr (pal_raddr),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta)
  );

  bpsc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .gray_mode (cfg_r.out_format),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta),
    .pal_rdata (pal_rdata),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready)) else $error("input stalled with free output");
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_meta)))
    else $error("waiting word lost in palette-read stage");
  a_rdata_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> $stable(pal_rdata))
    else $error("palette data changed while stage held");

endmodule
